>>> rtl/arh_pkg.sv
`timescale 1ns / 1ps
// Package: payload types, lane constants and the single AES round function.
package arh_pkg;

    typedef struct packed {
        logic [63:0] head_lo;
        logic [63:0] head_hi;
        logic [63:0] tail_lo;
        logic [63:0] tail_hi;
        logic [63:0] message_length;
        logic        last_pair;
    } in_item_t;

    typedef struct packed {
        logic [63:0] hash_lo;
        logic [63:0] hash_hi;
    } out_item_t;

    // Snapshot handed to the mix pipeline: six round keys, the second set first.
    typedef struct packed {
        logic [127:0]      mix;
        logic [5:0][127:0] keys;
        logic              use_second;
        logic              zero;
    } fin_t;

    localparam logic [63:0] A_LO = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] A_HI = 64'h6c62272e07bb0142;
    localparam logic [63:0] B_LO = 64'hBB67AE8584CAA73B;
    localparam logic [63:0] B_HI = 64'h6A09E667F3BCC908;
    localparam logic [63:0] C_LO = 64'h428A2F98D728AE22;
    localparam logic [63:0] C_HI = 64'h3C6EF372FE94F82B;

    localparam logic [127:0] A_INIT  = {A_HI, A_LO};
    localparam logic [127:0] B_INIT  = {B_HI, B_LO};
    localparam logic [127:0] C_INIT  = {C_HI, C_LO};
    localparam logic [127:0] A2_INIT = {A_LO, A_HI};
    localparam logic [127:0] B2_INIT = {B_LO, B_HI};
    localparam logic [127:0] C2_INIT = {C_LO, C_HI};

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // SubBytes, ShiftRows, MixColumns, then XOR with the round key.
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k);
        logic [7:0]   b  [16];
        logic [7:0]   sh [16];
        logic [127:0] res;
        logic [7:0]   a0, a1, a2, a3;
        for (int i = 0; i < 16; i++)
        begin
            b[i] = s[8*i +: 8];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sh[r + 4*c] = SBOX[b[r + 4*((c + r) & 3)]];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = sh[4*c];
            a1 = sh[4*c + 1];
            a2 = sh[4*c + 2];
            a3 = sh[4*c + 3];
            res[32*c      +: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            res[32*c + 8  +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            res[32*c + 16 +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            res[32*c + 24 +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return res ^ k;
    endfunction

endpackage

>>> rtl/arh_lanes.sv
`timescale 1ns / 1ps
// Front end: input register, lane state update and the snapshot register for the mix.
module arh_lanes
    import arh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] seed,
    input  logic        item_valid,
    output logic        item_ready,
    input  in_item_t    item,
    output logic        fin_valid,
    input  logic        fin_ready,
    output fin_t        fin
);

    in_item_t     item_reg;
    logic         item_valid_reg;
    fin_t         fin_reg, fin_next;
    logic         fin_valid_reg;
    logic [127:0] la_reg, lb_reg, lc_reg, la2_reg, lb2_reg, lc2_reg;
    logic         parity_reg;

    logic         fin_slot_free, step;
    logic [63:0]  len, lm1, w64, left, right, mask;
    logic [3:0]   nb;
    logic [2:0]   shift_n;
    logic         is_zero, is_s8, is_s16, is_long, even, sel2, produce;
    logic [127:0] ka, kb, a_src, b_src, c_src, k_a, k_b, k_c1, k_c2;
    logic [127:0] ra, rb, rc1, rc2;

    assign fin_slot_free = !fin_valid_reg || fin_ready;
    assign item_ready    = !item_valid_reg || fin_slot_free;
    assign step          = item_valid_reg && fin_slot_free;

    always_comb
    begin
        len     = item_reg.message_length;
        lm1     = len - 64'd1;
        w64     = {len[31:0] ^ seed, len[31:0] ^ seed};
        is_zero = (len == 64'd0);
        is_s8   = !is_zero && (len <= 64'd8);
        is_s16  = (len > 64'd8) && (len <= 64'd16);
        is_long = (len > 64'd16);
        even    = lm1[5];
        sel2    = even && parity_reg;
        produce = !is_long || item_reg.last_pair;

        // short message of 1..8 bytes: keep the low length bytes
        nb = len[3:0];
        for (int i = 0; i < 8; i++)
        begin
            mask[8*i +: 8] = (4'(i) < nb) ? 8'hff : 8'h00;
        end
        left    = item_reg.head_lo & mask;
        shift_n = 3'(4'd8 - nb);
        right   = left << {shift_n, 3'b000};
        ka      = {left, right};
        kb      = {right, left};

        if (is_long)
        begin
            a_src = sel2 ? la2_reg : la_reg;
            b_src = sel2 ? lb2_reg : lb_reg;
            c_src = sel2 ? lc2_reg : lc_reg;
            k_a   = {item_reg.head_hi, item_reg.head_lo};
            k_b   = {item_reg.tail_hi, item_reg.tail_lo};
            k_c1  = k_a;
            k_c2  = k_b;
        end
        else if (is_s16)
        begin
            a_src = A_INIT;
            b_src = B_INIT;
            c_src = C_INIT;
            k_a   = {item_reg.head_lo ^ w64, item_reg.head_lo ^ w64};
            k_b   = {item_reg.tail_lo ^ w64, item_reg.tail_lo ^ w64};
            k_c1  = ka;
            k_c2  = kb;
        end
        else
        begin
            a_src = A_INIT;
            b_src = B_INIT;
            c_src = C_INIT;
            k_a   = ka;
            k_b   = kb;
            k_c1  = ka;
            k_c2  = kb;
        end

        ra  = aes_round(a_src, k_a);
        rb  = aes_round(b_src, k_b);
        rc1 = aes_round(c_src, k_c1);
        rc2 = aes_round(rc1, k_c2);

        fin_next.mix        = {w64, w64};
        fin_next.zero       = is_zero;
        fin_next.use_second = is_long && even;
        if (is_long)
        begin
            fin_next.keys[0] = sel2 ? ra  : la2_reg;
            fin_next.keys[1] = sel2 ? rb  : lb2_reg;
            fin_next.keys[2] = sel2 ? rc2 : lc2_reg;
            fin_next.keys[3] = sel2 ? la_reg : ra;
            fin_next.keys[4] = sel2 ? lb_reg : rb;
            fin_next.keys[5] = sel2 ? lc_reg : rc2;
        end
        else
        begin
            fin_next.keys[0] = la2_reg;
            fin_next.keys[1] = lb2_reg;
            fin_next.keys[2] = lc2_reg;
            fin_next.keys[3] = ra;
            fin_next.keys[4] = rb;
            fin_next.keys[5] = is_s16 ? C_INIT : rc2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            fin_valid_reg  <= 1'b0;
            parity_reg     <= 1'b0;
            la_reg         <= A_INIT;
            lb_reg         <= B_INIT;
            lc_reg         <= C_INIT;
            la2_reg        <= A2_INIT;
            lb2_reg        <= B2_INIT;
            lc2_reg        <= C2_INIT;
        end
        else
        begin
            if (item_ready)
            begin
                item_valid_reg <= item_valid;
            end
            if (fin_slot_free)
            begin
                fin_valid_reg <= step && produce;
            end
            if (step)
            begin
                if (produce)
                begin
                    parity_reg <= 1'b0;
                    la_reg     <= A_INIT;
                    lb_reg     <= B_INIT;
                    lc_reg     <= C_INIT;
                    la2_reg    <= A2_INIT;
                    lb2_reg    <= B2_INIT;
                    lc2_reg    <= C2_INIT;
                end
                else
                begin
                    parity_reg <= parity_reg ^ even;
                    if (sel2)
                    begin
                        la2_reg <= ra;
                        lb2_reg <= rb;
                        lc2_reg <= rc2;
                    end
                    else
                    begin
                        la_reg <= ra;
                        lb_reg <= rb;
                        lc_reg <= rc2;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            item_reg <= item;
        end
        if (step)
        begin
            fin_reg <= fin_next;
        end
    end

    assign fin_valid = fin_valid_reg;
    assign fin       = fin_reg;

endmodule

>>> rtl/arh_mix_stage.sv
`timescale 1ns / 1ps
// One stage of the final mix: an optional AES round on the mix value, then a register.
module arh_mix_stage
    import arh_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         up_valid,
    output logic         up_ready,
    input  fin_t         up_data,
    input  logic [127:0] round_key,
    input  logic         always_apply,
    output logic         down_valid,
    input  logic         down_ready,
    output fin_t         down_data
);

    fin_t data_reg, data_next;
    logic valid_reg;

    assign up_ready = !valid_reg || down_ready;

    always_comb
    begin
        data_next = up_data;
        if (always_apply || up_data.use_second)
        begin
            data_next.mix = aes_round(up_data.mix, round_key);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;

endmodule

>>> rtl/aes_round_hash128.sv
`timescale 1ns / 1ps
// Top level of the AES-round message hash: seed register, lane front end and mix pipeline.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------------
//  item     | item_valid / item_stall   | head/tail chunks, message_length, last_pair
//  result   | result_valid / result_stall | hash_lo, hash_hi
//  seed     | seed_we                   | seed_wdata (32 bits)
//
// One item is taken every cycle while item_stall is low. An item's path to its result runs
// through the input register, the lane update (up to two chained AES rounds for lane C)
// into the mix snapshot and then six one-round mix stages, the last of which is the
// output register.
// Each stage holds its contents while the next is full, so result_stall backs up
// the pipeline and reaches item_stall only when every stage is occupied.
// Reset clears all valid flags, the seed and returns the lanes to their constants.
module aes_round_hash128
    import arh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_we,
    input  logic [31:0] seed_wdata,
    input  logic        item_valid,
    output logic        item_stall,
    input  in_item_t    item,
    output logic        result_valid,
    input  logic        result_stall,
    output out_item_t   result
);

    localparam int NUM_ROUNDS = 6;

    logic [31:0]               seed_reg;
    logic                      item_ready;
    logic [NUM_ROUNDS:0]       stg_valid;
    logic [NUM_ROUNDS:0]       stg_ready;
    fin_t                      stg_data [NUM_ROUNDS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (seed_we)
        begin
            seed_reg <= seed_wdata;
        end
    end

    arh_lanes u_lanes (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed       (seed_reg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .fin_valid  (stg_valid[0]),
        .fin_ready  (stg_ready[0]),
        .fin        (stg_data[0])
    );

    assign item_stall = !item_ready;

    // second-set rounds come first and only run for an even chunk count
    for (genvar j = 0; j < NUM_ROUNDS; j++)
    begin : g_mix
        arh_mix_stage u_stage (
            .clk          (clk),
            .rst_n        (rst_n),
            .up_valid     (stg_valid[j]),
            .up_ready     (stg_ready[j]),
            .up_data      (stg_data[j]),
            .round_key    (stg_data[j].keys[j]),
            .always_apply (1'(j >= NUM_ROUNDS / 2)),
            .down_valid   (stg_valid[j+1]),
            .down_ready   (stg_ready[j+1]),
            .down_data    (stg_data[j+1])
        );
    end

    assign stg_ready[NUM_ROUNDS] = !result_stall;

    assign result_valid   = stg_valid[NUM_ROUNDS];
    assign result.hash_lo = stg_data[NUM_ROUNDS].zero ? 64'd0 : stg_data[NUM_ROUNDS].mix[63:0];
    assign result.hash_hi = stg_data[NUM_ROUNDS].zero ? 64'd0
                                                      : stg_data[NUM_ROUNDS].mix[127:64];

endmodule

>>> rtl/arh_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the hash block and its bind.
module arh_checker
    import arh_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      item_stall,
    input logic      result_valid,
    input logic      result_stall,
    input out_item_t result
);

    // back-pressure reaches the input only through a stalled result
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("item_stall without a stalled result");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !result_valid)
        else $error("result_valid straight after reset");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> result_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> $stable(result))
        else $error("result changed while stalled");

endmodule

bind aes_round_hash128 arh_checker u_arh_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
